@@ design/stack_machine_with_variables_core_macros.svh @@
// assertion macros for the stack machine core
`ifndef STACK_MACHINE_WITH_VARIABLES_CORE_MACROS_SVH
`define STACK_MACHINE_WITH_VARIABLES_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// property that holds at every edge out of reset
`define SMV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define SMV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SMV_ASSERT(lbl, prop, msg)
`define SMV_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ design/smv_pkg.sv @@
package smv_pkg;

	localparam int WORD_W     = 32;
	localparam int ENTRY_W    = 33;
	localparam int NAME_W     = 6;
	localparam int FUNC_W     = 3;
	localparam int STATUS_W   = 2;
	localparam int DEPTH_W    = 7;
	localparam int IN_DATA_W  = 40;
	localparam int IN_USER_W  = 4;
	localparam int OUT_DATA_W = 40;
	localparam int OUT_USER_W = 2;

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH    = 3'd0,
		FN_ADD     = 3'd1,
		FN_SUB     = 3'd2,
		FN_MULT    = 3'd3,
		FN_ASSIGN  = 3'd4,
		FN_PRINT   = 3'd5,
		FN_UNKNOWN = 3'd6
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE    = 2'd0,
		ST_PRINTED = 2'd1,
		ST_ERROR   = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CNT_KEEP,
		CNT_INC,
		CNT_DEC1,
		CNT_DEC2
	} cnt_op_t;

	typedef enum logic [1:0] {
		TOP_KEEP,
		TOP_NEW,
		TOP_NEXT,
		TOP_RD_A
	} top_sel_t;

	typedef enum logic [1:0] {
		NXT_KEEP,
		NXT_TOP,
		NXT_RD_A,
		NXT_RD_B
	} next_sel_t;

	typedef struct packed {
		func_t               func;
		logic                push_is_name;
		logic [WORD_W-1:0]   push_literal;
		logic [NAME_W-1:0]   push_name;
		logic                halted;
		logic                full;
		logic                has_one;
		logic                has_two;
		logic                name_ok;
		logic                top_def;
		logic                next_def;
		logic [ENTRY_W-1:0]  top;
		logic [ENTRY_W-1:0]  next;
		logic [WORD_W-1:0]   top_var;
		logic [WORD_W-1:0]   next_var;
	} exec_in_t;

	typedef struct packed {
		status_t             status;
		logic [WORD_W-1:0]   print_value;
		cnt_op_t             cnt_op;
		top_sel_t            top_sel;
		next_sel_t           next_sel;
		logic                stk_wr;
		logic                stk_wr_low;
		logic                var_wr;
		logic                halt;
		logic [ENTRY_W-1:0]  top_val;
	} exec_out_t;

endpackage

@@ design/smv_exec.sv @@
module smv_exec (
	input  smv_pkg::exec_in_t  ei,
	output smv_pkg::exec_out_t eo
);

	logic [smv_pkg::WORD_W-1:0] val_top;
	logic [smv_pkg::WORD_W-1:0] val_next;
	logic [smv_pkg::WORD_W-1:0] prod;
	logic [smv_pkg::WORD_W-1:0] res;
	logic                       ok_top;
	logic                       ok_next;
	logic                       err;

	always_comb begin
		val_top  = ei.top[smv_pkg::WORD_W] ? ei.top_var : ei.top[smv_pkg::WORD_W-1:0];
		val_next = ei.next[smv_pkg::WORD_W] ? ei.next_var : ei.next[smv_pkg::WORD_W-1:0];
		ok_top   = !ei.top[smv_pkg::WORD_W] || ei.top_def;
		ok_next  = !ei.next[smv_pkg::WORD_W] || ei.next_def;
		prod     = val_next * val_top;
		case (ei.func)
			smv_pkg::FN_ADD: res = val_next + val_top;
			smv_pkg::FN_SUB: res = val_next - val_top;
			default:         res = prod;
		endcase
	end

	always_comb begin
		err            = 1'b0;
		eo.status      = smv_pkg::ST_DONE;
		eo.print_value = '0;
		eo.cnt_op      = smv_pkg::CNT_KEEP;
		eo.top_sel     = smv_pkg::TOP_KEEP;
		eo.next_sel    = smv_pkg::NXT_KEEP;
		eo.stk_wr      = 1'b0;
		eo.stk_wr_low  = 1'b0;
		eo.var_wr      = 1'b0;
		eo.halt        = 1'b0;
		eo.top_val     = {1'b0, res};
		if (ei.halted) begin
			eo.status = smv_pkg::ST_IGNORED;
		end else begin
			unique case (ei.func) inside
				smv_pkg::FN_PUSH: begin
					if (ei.full || (ei.push_is_name && !ei.name_ok)) begin
						err = 1'b1;
					end else begin
						eo.top_val  = ei.push_is_name ?
							{1'b1, {(smv_pkg::WORD_W-smv_pkg::NAME_W){1'b0}}, ei.push_name} :
							{1'b0, ei.push_literal};
						eo.stk_wr   = 1'b1;
						eo.cnt_op   = smv_pkg::CNT_INC;
						eo.top_sel  = smv_pkg::TOP_NEW;
						eo.next_sel = smv_pkg::NXT_TOP;
					end
				end
				smv_pkg::FN_ADD, smv_pkg::FN_SUB, smv_pkg::FN_MULT: begin
					if (!ei.has_two) begin
						err = 1'b1;
					end else if (!ok_top || !ok_next) begin
						// both operands are gone already
						err         = 1'b1;
						eo.cnt_op   = smv_pkg::CNT_DEC2;
						eo.top_sel  = smv_pkg::TOP_RD_A;
						eo.next_sel = smv_pkg::NXT_RD_B;
					end else begin
						eo.stk_wr     = 1'b1;
						eo.stk_wr_low = 1'b1;
						eo.cnt_op     = smv_pkg::CNT_DEC1;
						eo.top_sel    = smv_pkg::TOP_NEW;
						eo.next_sel   = smv_pkg::NXT_RD_A;
					end
				end
				smv_pkg::FN_ASSIGN: begin
					if (!ei.has_two) begin
						err = 1'b1;
					end else begin
						eo.cnt_op   = smv_pkg::CNT_DEC2;
						eo.top_sel  = smv_pkg::TOP_RD_A;
						eo.next_sel = smv_pkg::NXT_RD_B;
						if (!ei.next[smv_pkg::WORD_W] || ei.top[smv_pkg::WORD_W]) begin
							err = 1'b1;
						end else begin
							eo.var_wr = 1'b1;
						end
					end
				end
				smv_pkg::FN_PRINT: begin
					if (!ei.has_one || !ei.top[smv_pkg::WORD_W] || !ei.top_def) begin
						err = 1'b1;
					end else begin
						eo.status      = smv_pkg::ST_PRINTED;
						eo.print_value = ei.top_var;
						eo.cnt_op      = smv_pkg::CNT_DEC1;
						eo.top_sel     = smv_pkg::TOP_NEXT;
						eo.next_sel    = smv_pkg::NXT_RD_A;
					end
				end
				default: begin
					err = 1'b1;
				end
			endcase
			if (err) begin
				eo.status      = smv_pkg::ST_ERROR;
				eo.print_value = '0;
				eo.halt        = 1'b1;
			end
		end
	end

endmodule

@@ design/stack_machine_with_variables_core.sv @@
// stack machine core with a variable table, one instruction word in, one status word out
// the result word is registered when the execute stage fires, which waits while the output
// holds an untaken word; no new word is taken while one is in the execute stage; stack and
// variable memories are read on the accept edge and written back when that stage fires
// reset: arst_n clears depth, halt flag, defined flags and both handshakes; memories keep data
`include "stack_machine_with_variables_core_macros.svh"
module stack_machine_with_variables_core #(
	parameter int STACK_DEPTH = 64,
	parameter int NAME_COUNT  = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [smv_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // push_literal, push_name
	input  logic [smv_pkg::IN_USER_W-1:0]    s_axis_tuser,  // func, push_is_name
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [smv_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // print_value, depth_after
	output logic [smv_pkg::OUT_USER_W-1:0]   m_axis_tuser   // status
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int NW = (NAME_COUNT > 1) ? $clog2(NAME_COUNT) : 1;
	localparam int DW = smv_pkg::DEPTH_W;
	localparam int WW = smv_pkg::WORD_W;
	localparam int EW = smv_pkg::ENTRY_W;
	localparam int NMW = smv_pkg::NAME_W;

	logic [EW-1:0]         stack_mem [STACK_DEPTH];
	logic [WW-1:0]         var_mem   [NAME_COUNT];

	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_nxt;
	logic                  halted_q;
	logic [EW-1:0]         top_q;
	logic [EW-1:0]         next_q;
	logic [NAME_COUNT-1:0] def_q;

	logic                  valid_s1;
	logic [smv_pkg::FUNC_W-1:0] func_s1;
	logic                  is_name_s1;
	logic [WW-1:0]         literal_s1;
	logic [NMW-1:0]        name_s1;
	logic [EW-1:0]         rd_a_s1;
	logic [EW-1:0]         rd_b_s1;
	logic [WW-1:0]         var_top_s1;
	logic [WW-1:0]         var_next_s1;

	logic                  out_valid_q;
	smv_pkg::status_t      status_q;
	logic [WW-1:0]         pv_q;
	logic [DW-1:0]         depth_q;

	logic                  in_fire;
	logic                  s1_fire;
	logic [AW-1:0]         rd_a_idx;
	logic [AW-1:0]         rd_b_idx;
	logic [AW-1:0]         wr_idx;
	logic [NW-1:0]         top_idx;
	logic [NW-1:0]         next_idx;

	smv_pkg::exec_in_t     ex_in;
	smv_pkg::exec_out_t    ex_out;

	assign s_axis_tready = !valid_s1;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign s1_fire       = valid_s1 && (!out_valid_q || m_axis_tready);

	// refill slots: third and fourth entry from the top
	assign rd_a_idx = AW'(count_q) - AW'(3);
	assign rd_b_idx = AW'(count_q) - AW'(4);
	assign wr_idx   = ex_out.stk_wr_low ? (AW'(count_q) - AW'(2)) : AW'(count_q);
	assign top_idx  = top_q[NW-1:0];
	assign next_idx = next_q[NW-1:0];

	always_ff @(posedge clk) begin
		if (in_fire) begin
			rd_a_s1 <= stack_mem[rd_a_idx];
			rd_b_s1 <= stack_mem[rd_b_idx];
		end
		if (s1_fire && ex_out.stk_wr) begin
			stack_mem[wr_idx] <= ex_out.top_val;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			var_top_s1  <= var_mem[top_idx];
			var_next_s1 <= var_mem[next_idx];
		end
		if (s1_fire && ex_out.var_wr) begin
			var_mem[next_idx] <= top_q[WW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_s1    <= s_axis_tuser[smv_pkg::FUNC_W-1:0];
			is_name_s1 <= s_axis_tuser[smv_pkg::FUNC_W];
			literal_s1 <= s_axis_tdata[WW-1:0];
			name_s1    <= s_axis_tdata[WW+NMW-1:WW];
		end
	end

	always_comb begin
		ex_in.func         = smv_pkg::func_t'(func_s1);
		ex_in.push_is_name = is_name_s1;
		ex_in.push_literal = literal_s1;
		ex_in.push_name    = name_s1;
		ex_in.halted       = halted_q;
		ex_in.full         = count_q >= CW'(STACK_DEPTH);
		ex_in.has_one      = count_q != '0;
		ex_in.has_two      = count_q >= CW'(2);
		ex_in.name_ok      = {{(32-NMW){1'b0}}, name_s1} < 32'(NAME_COUNT);
		ex_in.top_def      = top_q[WW] && def_q[top_idx];
		ex_in.next_def     = next_q[WW] && def_q[next_idx];
		ex_in.top          = top_q;
		ex_in.next         = next_q;
		ex_in.top_var      = var_top_s1;
		ex_in.next_var     = var_next_s1;
	end

	smv_exec u_exec (
		.ei (ex_in),
		.eo (ex_out)
	);

	always_comb begin
		case (ex_out.cnt_op)
			smv_pkg::CNT_INC:  count_nxt = count_q + CW'(1);
			smv_pkg::CNT_DEC1: count_nxt = count_q - CW'(1);
			smv_pkg::CNT_DEC2: count_nxt = count_q - CW'(2);
			default:           count_nxt = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			halted_q    <= 1'b0;
			def_q       <= '0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end
			if (s1_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (s1_fire) begin
				count_q <= count_nxt;
				if (ex_out.halt) begin
					halted_q <= 1'b1;
				end
				if (ex_out.var_wr) begin
					def_q[next_idx] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			status_q <= ex_out.status;
			pv_q     <= ex_out.print_value;
			depth_q  <= DW'(count_nxt);
			case (ex_out.top_sel)
				smv_pkg::TOP_NEW:  top_q <= ex_out.top_val;
				smv_pkg::TOP_NEXT: top_q <= next_q;
				smv_pkg::TOP_RD_A: top_q <= rd_a_s1;
				default:           top_q <= top_q;
			endcase
			case (ex_out.next_sel)
				smv_pkg::NXT_TOP:  next_q <= top_q;
				smv_pkg::NXT_RD_A: next_q <= rd_a_s1;
				smv_pkg::NXT_RD_B: next_q <= rd_b_s1;
				default:           next_q <= next_q;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(smv_pkg::OUT_DATA_W-WW-DW){1'b0}}, depth_q, pv_q};
	assign m_axis_tuser  = status_q;

	`SMV_ASSERT(a_depth_bound, count_q <= CW'(STACK_DEPTH), "stack depth beyond capacity")
	`SMV_ASSERT_NEXT(a_halt_sticky, halted_q, halted_q, "halt flag dropped")
	`SMV_ASSERT_NEXT(a_error_halts, s1_fire && ex_out.status == smv_pkg::ST_ERROR, halted_q, "error without halt")
	`SMV_ASSERT_NEXT(a_ignored_keeps_depth, s1_fire && halted_q, $stable(count_q) && $stable(top_q), "ignored word changed the stack")

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;

	localparam int STK_N   = 64;
	localparam int NAMES_N = 64;

	typedef logic [smv_pkg::NAME_W-1:0] name_t;

	typedef struct packed {
		smv_pkg::func_t                func;
		logic                          is_name;
		logic [smv_pkg::WORD_W-1:0]    lit;
		logic [smv_pkg::NAME_W-1:0]    name;
	} instr_t;

	typedef struct packed {
		smv_pkg::status_t              status;
		logic [smv_pkg::WORD_W-1:0]    value;
		logic [smv_pkg::DEPTH_W-1:0]   depth;
	} outcome_t;

	typedef enum int {
		FLT_FULL,
		FLT_FEW_BIN,
		FLT_FEW_ASSIGN,
		FLT_UNDEF_TOP,
		FLT_UNDEF_NEXT,
		FLT_TARGET_LIT,
		FLT_VALUE_NAME,
		FLT_PRINT_EMPTY,
		FLT_PRINT_LIT,
		FLT_PRINT_UNDEF,
		FLT_UNKNOWN
	} fault_t;

	class stack_predictor;
		logic [smv_pkg::ENTRY_W-1:0] stk [STK_N];
		int                          count;
		logic [smv_pkg::WORD_W-1:0]  vars [NAMES_N];
		bit                          defd [NAMES_N];
		bit                          halted;
		int                          mismatches;
		outcome_t                    expected_words [$];

		function new();
			count      = 0;
			halted     = 0;
			mismatches = 0;
			foreach (defd[i]) defd[i] = 0;
		endfunction

		function logic [smv_pkg::ENTRY_W-1:0] pop();
			count--;
			return stk[count];
		endfunction

		function void push(logic [smv_pkg::ENTRY_W-1:0] e);
			stk[count] = e;
			count++;
		endfunction

		function bit resolve(logic [smv_pkg::ENTRY_W-1:0] e,
				output logic [smv_pkg::WORD_W-1:0] v);
			v = e[smv_pkg::WORD_W-1:0];
			if (!e[smv_pkg::WORD_W]) return 1;
			if (e[smv_pkg::WORD_W-1:0] >= NAMES_N || !defd[e[smv_pkg::NAME_W-1:0]]) return 0;
			v = vars[e[smv_pkg::NAME_W-1:0]];
			return 1;
		endfunction

		function smv_pkg::status_t execute(instr_t it, output logic [smv_pkg::WORD_W-1:0] pv);
			logic [smv_pkg::ENTRY_W-1:0] top;
			logic [smv_pkg::ENTRY_W-1:0] nxt;
			logic [smv_pkg::WORD_W-1:0]  a;
			logic [smv_pkg::WORD_W-1:0]  b;
			pv = '0;
			case (it.func) inside
				smv_pkg::FN_PUSH: begin
					if (count >= STK_N) return smv_pkg::ST_ERROR;
					if (it.is_name) begin
						if (it.name >= NAMES_N) return smv_pkg::ST_ERROR;
						push({1'b1, {(smv_pkg::WORD_W-smv_pkg::NAME_W){1'b0}}, it.name});
					end else begin
						push({1'b0, it.lit});
					end
					return smv_pkg::ST_DONE;
				end
				smv_pkg::FN_ADD, smv_pkg::FN_SUB, smv_pkg::FN_MULT: begin
					if (count < 2) return smv_pkg::ST_ERROR;
					top = pop();
					nxt = pop();
					if (!resolve(top, b)) return smv_pkg::ST_ERROR;
					if (!resolve(nxt, a)) return smv_pkg::ST_ERROR;
					case (it.func)
						smv_pkg::FN_ADD: push({1'b0, a + b});
						smv_pkg::FN_SUB: push({1'b0, a - b});
						default:         push({1'b0, a * b});
					endcase
					return smv_pkg::ST_DONE;
				end
				smv_pkg::FN_ASSIGN: begin
					if (count < 2) return smv_pkg::ST_ERROR;
					top = pop();
					nxt = pop();
					if (!nxt[smv_pkg::WORD_W] || top[smv_pkg::WORD_W]) return smv_pkg::ST_ERROR;
					if (nxt[smv_pkg::WORD_W-1:0] >= NAMES_N) return smv_pkg::ST_ERROR;
					vars[nxt[smv_pkg::NAME_W-1:0]] = top[smv_pkg::WORD_W-1:0];
					defd[nxt[smv_pkg::NAME_W-1:0]] = 1;
					return smv_pkg::ST_DONE;
				end
				smv_pkg::FN_PRINT: begin
					if (count == 0) return smv_pkg::ST_ERROR;
					top = stk[count-1];
					if (!top[smv_pkg::WORD_W]) return smv_pkg::ST_ERROR;
					if (top[smv_pkg::WORD_W-1:0] >= NAMES_N || !defd[top[smv_pkg::NAME_W-1:0]])
						return smv_pkg::ST_ERROR;
					pv = vars[top[smv_pkg::NAME_W-1:0]];
					count--;
					return smv_pkg::ST_PRINTED;
				end
				default: return smv_pkg::ST_ERROR;
			endcase
		endfunction

		function void take_instr(instr_t it);
			outcome_t                   o;
			logic [smv_pkg::WORD_W-1:0] pv;
			pv = '0;
			if (halted) begin
				o.status = smv_pkg::ST_IGNORED;
			end else begin
				o.status = execute(it, pv);
				if (o.status == smv_pkg::ST_ERROR) begin
					halted = 1;
					pv     = '0;
				end
			end
			o.value = pv;
			o.depth = count[smv_pkg::DEPTH_W-1:0];
			expected_words.push_back(o);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_word(logic [smv_pkg::STATUS_W-1:0] st, logic [smv_pkg::WORD_W-1:0] value,
				logic [smv_pkg::DEPTH_W-1:0] depth);
			outcome_t o;
			if (expected_words.size() == 0) begin
				report($sformatf("unexpected word, status %0d depth %0d", st, depth));
				return;
			end
			o = expected_words.pop_front();
			if (st !== o.status)
				report($sformatf("status %0d, expected %0d", st, o.status));
			if (value !== o.value)
				report($sformatf("print_value %h, expected %h", value, o.value));
			if (depth !== o.depth)
				report($sformatf("depth_after %0d, expected %0d", depth, o.depth));
		endtask
	endclass

	logic                              clk;
	logic                              arst_n;
	logic                              s_axis_tvalid;
	logic                              s_axis_tready;
	logic [smv_pkg::IN_DATA_W-1:0]     s_axis_tdata;   // push_literal, push_name
	logic [smv_pkg::IN_USER_W-1:0]     s_axis_tuser;   // func, push_is_name
	logic                              m_axis_tvalid;
	logic                              m_axis_tready;
	logic [smv_pkg::OUT_DATA_W-1:0]    m_axis_tdata;   // print_value, depth_after
	logic [smv_pkg::OUT_USER_W-1:0]    m_axis_tuser;   // status

	stack_predictor sb;
	int             tx_sent;
	int             rx_taken;
	bit             tx_fast;
	bit             rx_fast;
	bit             rx_hold_req;

	stack_machine_with_variables_core #(
		.STACK_DEPTH(STK_N),
		.NAME_COUNT (NAMES_N)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function logic [smv_pkg::WORD_W-1:0] rand_lit();
		case ($urandom_range(0, 5))
			0:       return 32'h0000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'h8000_0000;
			3:       return 32'hffff_ffff;
			4:       return $urandom_range(0, 20);
			default: return $urandom;
		endcase
	endfunction

	function instr_t mk(smv_pkg::func_t f, logic isn, logic [smv_pkg::WORD_W-1:0] lit,
			name_t name);
		instr_t it;
		it.func    = f;
		it.is_name = isn;
		it.lit     = lit;
		it.name    = name;
		return it;
	endfunction

	function instr_t push_lit(logic [smv_pkg::WORD_W-1:0] v);
		return mk(smv_pkg::FN_PUSH, 1'b0, v, name_t'($urandom_range(0, 63)));
	endfunction

	function instr_t push_nm(name_t n);
		return mk(smv_pkg::FN_PUSH, 1'b1, $urandom, n);
	endfunction

	function instr_t op(smv_pkg::func_t f);
		return mk(f, 1'($urandom_range(0, 1)), $urandom, name_t'($urandom_range(0, 63)));
	endfunction

	function instr_t arith();
		return op(smv_pkg::func_t'($urandom_range(smv_pkg::FN_ADD, smv_pkg::FN_MULT)));
	endfunction

	// random name whose defined flag matches, or -1
	function int name_with(bit want_defined);
		int start;
		start = $urandom_range(0, NAMES_N-1);
		for (int i = 0; i < NAMES_N; i++)
			if (sb.defd[(start+i) % NAMES_N] == want_defined)
				return (start+i) % NAMES_N;
		return -1;
	endfunction

	function bit top_undef();
		logic [smv_pkg::ENTRY_W-1:0] top;
		if (sb.count == 0) return 0;
		top = sb.stk[sb.count-1];
		return top[smv_pkg::WORD_W] && !sb.defd[top[smv_pkg::NAME_W-1:0]];
	endfunction

	function bit assign_owed();
		logic [smv_pkg::ENTRY_W-1:0] top;
		logic [smv_pkg::ENTRY_W-1:0] nxt;
		if (sb.count < 2) return 0;
		top = sb.stk[sb.count-1];
		nxt = sb.stk[sb.count-2];
		return !top[smv_pkg::WORD_W] && nxt[smv_pkg::WORD_W] && !sb.defd[nxt[smv_pkg::NAME_W-1:0]];
	endfunction

	// error-free instruction; an undefined name is always followed by a literal and an assign
	function instr_t next_legal(int push_w);
		int                          c;
		int                          n;
		logic [smv_pkg::ENTRY_W-1:0] top;
		logic [smv_pkg::ENTRY_W-1:0] nxt;
		c   = sb.count;
		top = (c > 0) ? sb.stk[c-1] : '0;
		nxt = (c > 1) ? sb.stk[c-2] : '0;
		if (top_undef()) return push_lit(rand_lit());
		if (c > 1 && !top[smv_pkg::WORD_W] && nxt[smv_pkg::WORD_W])
			if (assign_owed() || $urandom_range(0, 99) < 40) return op(smv_pkg::FN_ASSIGN);
		if (c > 0 && top[smv_pkg::WORD_W] && $urandom_range(0, 99) < 50)
			return op(smv_pkg::FN_PRINT);
		if (c < STK_N && (c < 2 || $urandom_range(0, 99) < push_w)) begin
			if ($urandom_range(0, 1)) begin
				if (c <= STK_N-2 && $urandom_range(0, 1))
					return push_nm(name_t'($urandom_range(0, 63)));
				n = name_with(1'b1);
				if (n >= 0) return push_nm(name_t'(n));
			end
			return push_lit(rand_lit());
		end
		return arith();
	endfunction

	task send(instr_t it);
		int gap;
		if (tx_sent % 40 == 0) tx_fast = ($urandom_range(0, 3) == 0);
		tx_sent++;
		gap = tx_fast ? 0 : $urandom_range(0, 16);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata  = {{(smv_pkg::IN_DATA_W-smv_pkg::WORD_W-smv_pkg::NAME_W){1'b0}},
			it.name, it.lit};
		s_axis_tuser  = {it.is_name, it.func};
		s_axis_tvalid = 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.take_instr(it);
	endtask

	task wait_idle();
		while (sb.expected_words.size() != 0) @(posedge clk);
	endtask

	task settle();
		while (top_undef() || assign_owed()) send(next_legal(50));
	endtask

	task fill();
		int n;
		settle();
		while (sb.count < STK_N) begin
			n = name_with(1'b1);
			if (n >= 0 && $urandom_range(0, 1)) send(push_nm(name_t'(n)));
			else send(push_lit(rand_lit()));
		end
	endtask

	task make_room(int need);
		while (sb.count > STK_N-need) send(arith());
	endtask

	task drain_to_one();
		while (sb.count > 1) send(arith());
	endtask

	task inject_fault();
		fault_t kind;
		int     n;
		settle();
		kind = fault_t'($urandom_range(FLT_FULL, FLT_UNKNOWN));
		n    = name_with(1'b0);
		if (n < 0 && (kind == FLT_UNDEF_TOP || kind == FLT_UNDEF_NEXT || kind == FLT_PRINT_UNDEF))
			kind = FLT_UNKNOWN;
		case (kind)
			FLT_FULL: begin
				while (sb.count < STK_N) send(push_lit(rand_lit()));
				if ($urandom_range(0, 1)) send(push_nm(name_t'($urandom_range(0, 63))));
				else send(push_lit(rand_lit()));
			end
			FLT_FEW_BIN: begin
				drain_to_one();
				send(arith());
			end
			FLT_FEW_ASSIGN: begin
				drain_to_one();
				send(op(smv_pkg::FN_ASSIGN));
			end
			FLT_UNDEF_TOP: begin
				make_room(2);
				if (sb.count == 0) send(push_lit(rand_lit()));
				send(push_nm(name_t'(n)));
				send(arith());
			end
			FLT_UNDEF_NEXT: begin
				make_room(2);
				send(push_nm(name_t'(n)));
				send(push_lit(rand_lit()));
				send(arith());
			end
			FLT_TARGET_LIT: begin
				make_room(2);
				send(push_lit(rand_lit()));
				send(push_lit(rand_lit()));
				send(op(smv_pkg::FN_ASSIGN));
			end
			FLT_VALUE_NAME: begin
				make_room(2);
				send(push_nm(name_t'($urandom_range(0, 63))));
				send(push_nm(name_t'($urandom_range(0, 63))));
				send(op(smv_pkg::FN_ASSIGN));
			end
			FLT_PRINT_EMPTY: begin
				// only a name at the bottom lets the stack empty without an error
				drain_to_one();
				if (sb.count == 1 && sb.stk[0][smv_pkg::WORD_W]) send(op(smv_pkg::FN_PRINT));
				send(op(smv_pkg::FN_PRINT));
			end
			FLT_PRINT_LIT: begin
				make_room(1);
				send(push_lit(rand_lit()));
				send(op(smv_pkg::FN_PRINT));
			end
			FLT_PRINT_UNDEF: begin
				make_room(1);
				send(push_nm(name_t'(n)));
				send(op(smv_pkg::FN_PRINT));
			end
			default: send(op(smv_pkg::FN_UNKNOWN));
		endcase
	endtask

	initial begin
		sb            = new();
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		tx_sent       = 0;
		tx_fast       = 1'b0;
		rx_hold_req   = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wrap on add, extremes of literal and name, every operation
		send(push_lit(32'h7fff_ffff));
		send(push_lit(32'h0000_0001));
		send(op(smv_pkg::FN_ADD));
		send(push_nm(6'd63));
		send(push_lit(32'h8000_0000));
		send(op(smv_pkg::FN_ASSIGN));
		send(push_nm(6'd63));
		send(op(smv_pkg::FN_PRINT));
		send(push_nm(6'd0));
		send(push_lit(32'hffff_ffff));
		send(op(smv_pkg::FN_ASSIGN));
		send(push_nm(6'd0));
		send(push_nm(6'd63));
		send(op(smv_pkg::FN_SUB));
		send(push_lit(32'hffff_ffff));
		send(op(smv_pkg::FN_MULT));
		send(push_lit(32'h0000_0000));
		send(op(smv_pkg::FN_ADD));
		send(push_lit(32'h0000_0005));
		send(op(smv_pkg::FN_SUB));
		send(op(smv_pkg::FN_MULT));
		send(push_nm(6'd0));
		send(op(smv_pkg::FN_PRINT));

		for (int i = 0; i < 170; i++) send(next_legal(50));

		// receiver holds off while words keep coming
		tx_fast     = 1'b1;
		rx_hold_req = 1'b1;
		for (int i = 0; i < 100; i++) send(next_legal(70));

		@(negedge clk);
		s_axis_tvalid = 1'b0;
		wait_idle();

		fill();
		for (int i = 0; i < 150; i++) send(next_legal(30));

		inject_fault();
		for (int i = 0; i < 12; i++)
			send(mk(smv_pkg::func_t'($urandom_range(smv_pkg::FN_PUSH, smv_pkg::FN_UNKNOWN)),
				1'($urandom_range(0, 1)), $urandom, name_t'($urandom_range(0, 63))));

		@(negedge clk);
		s_axis_tvalid = 1'b0;
		wait_idle();
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		int gap;
		int held;
		m_axis_tready = 1'b0;
		rx_taken      = 0;
		rx_fast       = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				m_axis_tready = 1'b0;
				held = 0;
				while (held < 300) begin
					@(negedge clk);
					held++;
				end
				rx_hold_req = 1'b0;
			end
			if (rx_taken % 40 == 0) rx_fast = ($urandom_range(0, 3) == 0);
			rx_taken++;
			gap = rx_fast ? 0 : $urandom_range(0, 16);
			if (gap > 0) begin
				m_axis_tready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready = 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			sb.check_word(m_axis_tuser, m_axis_tdata[smv_pkg::WORD_W-1:0],
				m_axis_tdata[smv_pkg::WORD_W+smv_pkg::DEPTH_W-1:smv_pkg::WORD_W]);
		end
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
